FILE: rtl/core/address_keyed_call_counter_core_assert.svh
// Assertion macros used by the call counter checker.
`ifndef ADDRESS_KEYED_CALL_COUNTER_CORE_ASSERT_SVH
`define ADDRESS_KEYED_CALL_COUNTER_CORE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define AKCC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("call counter check failed");

// Next-cycle implication, held off during reset.
`define AKCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("call counter check failed");

`endif

FILE: rtl/core/akcc_pkg.sv
// Shared constants and types of the call counter.
package akcc_pkg;

	localparam int AKCC_ENTRIES    = 64;
	localparam int AKCC_ADDR_BITS  = 48;
	localparam int AKCC_COUNT_BITS = 32;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_READ   = 1'b1;

	// Control bits that ride along with a word through the cell chain.
	typedef struct packed {
		logic op;     // OP_RECORD or OP_READ
		logic done;   // an entry was matched, inserted or read
		logic fresh;  // the entry was inserted by this word
	} tok_ctl_t;

endpackage

FILE: rtl/core/akcc_if.sv
// Request and response channel interfaces of the call counter.
interface akcc_req_if #(
	parameter int ADDR_BITS = 48,
	parameter int IDX_BITS  = 6
);
	logic                 valid;
	logic                 ready;
	logic                 func;
	logic [ADDR_BITS-1:0] address;
	logic [IDX_BITS-1:0]  index;

	modport source (output valid, func, address, index, input ready);
	modport sink   (input valid, func, address, index, output ready);
endinterface

interface akcc_rsp_if #(
	parameter int ADDR_BITS  = 48,
	parameter int COUNT_BITS = 32,
	parameter int IDX_BITS   = 6
);
	logic                  valid;
	logic                  ready;
	logic [IDX_BITS-1:0]   entry_index;
	logic [ADDR_BITS-1:0]  entry_address;
	logic [COUNT_BITS-1:0] hit_count;
	logic                  was_new;
	logic                  entry_valid;
	logic                  dropped_full;

	modport source (output valid, entry_index, entry_address, hit_count, was_new,
		entry_valid, dropped_full, input ready);
	modport sink   (input valid, entry_index, entry_address, hit_count, was_new,
		entry_valid, dropped_full, output ready);
endinterface

FILE: rtl/core/akcc_cell.sv
// One table entry of the call counter chain: stores an address and count, checks the passing word.
module akcc_cell import akcc_pkg::*; #(
	parameter int POS        = 0,
	parameter int ADDR_BITS  = AKCC_ADDR_BITS,
	parameter int COUNT_BITS = AKCC_COUNT_BITS,
	parameter int IDX_BITS   = 6,
	parameter int FILL_BITS  = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [FILL_BITS-1:0]  fill,
	input  logic                  hold,
	input  logic                  in_vld,
	input  tok_ctl_t              in_ctl,
	input  logic [ADDR_BITS-1:0]  in_key,
	input  logic [IDX_BITS-1:0]   in_idx,
	input  logic [IDX_BITS-1:0]   in_ridx,
	input  logic [COUNT_BITS-1:0] in_rcnt,
	output logic                  out_vld,
	output tok_ctl_t              out_ctl,
	output logic [ADDR_BITS-1:0]  out_key,
	output logic [IDX_BITS-1:0]   out_idx,
	output logic [IDX_BITS-1:0]   out_ridx,
	output logic [COUNT_BITS-1:0] out_rcnt
);

	localparam logic [FILL_BITS-1:0] POS_F = FILL_BITS'(POS);
	localparam logic [IDX_BITS-1:0]  POS_I = IDX_BITS'(POS);

	logic [ADDR_BITS-1:0]  addr_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic                  vld_q;
	tok_ctl_t              ctl_q;
	logic [ADDR_BITS-1:0]  key_q;
	logic [IDX_BITS-1:0]   idx_q;
	logic [IDX_BITS-1:0]   ridx_q;
	logic [COUNT_BITS-1:0] rcnt_q;

	logic                  occupied;
	logic                  rec_live;
	logic                  hit_here;
	logic                  ins_here;
	logic                  rd_here;
	logic [COUNT_BITS-1:0] cnt_next;

	assign occupied = POS_F < fill;
	assign rec_live = in_vld && (in_ctl.op == OP_RECORD) && !in_ctl.done;
	assign hit_here = rec_live && occupied && (addr_q == in_key);
	assign ins_here = rec_live && (POS_F == fill);
	assign rd_here  = in_vld && (in_ctl.op == OP_READ) && occupied && (in_idx == POS_I);
	assign cnt_next = (&cnt_q) ? cnt_q : cnt_q + COUNT_BITS'(1);

	// Entry storage: written only by the word that hits or claims this slot.
	always_ff @(posedge clk) begin
		if (hit_here) begin
			cnt_q <= cnt_next;
		end else if (ins_here) begin
			addr_q <= in_key;
			cnt_q  <= COUNT_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_vld || (vld_q && hold);
		end
	end

	// Hand the word to the next cell, folding in this entry's outcome.
	always_ff @(posedge clk) begin
		if (in_vld) begin
			ctl_q.op    <= in_ctl.op;
			ctl_q.done  <= in_ctl.done || hit_here || ins_here || rd_here;
			ctl_q.fresh <= in_ctl.fresh || ins_here;
			key_q       <= rd_here ? addr_q : in_key;
			idx_q       <= in_idx;
			ridx_q      <= (hit_here || ins_here || rd_here) ? POS_I : in_ridx;
			if (hit_here) begin
				rcnt_q <= cnt_next;
			end else if (ins_here) begin
				rcnt_q <= COUNT_BITS'(1);
			end else if (rd_here) begin
				rcnt_q <= cnt_q;
			end else begin
				rcnt_q <= in_rcnt;
			end
		end
	end

	assign out_vld  = vld_q;
	assign out_ctl  = ctl_q;
	assign out_key  = key_q;
	assign out_idx  = idx_q;
	assign out_ridx = ridx_q;
	assign out_rcnt = rcnt_q;

endmodule

FILE: rtl/core/address_keyed_call_counter_core.sv
// Top level of the address keyed call counter: a chain of table cells.
//
// Usage:
//   req carries one word per item: func selects record (address) or read (index).
//   rsp returns exactly one word per item, in order.
//   A record word walks the cell chain one cell per cycle. The cell holding a
//   matching address bumps its count (saturating); otherwise the first empty
//   cell, the one at the fill level, takes the address with count one. With
//   every cell filled the address is dropped and dropped_full is raised.
//   A read word picks up address and count of the cell at index; past the fill
//   level it returns entry_valid low and all other fields zero.
// Path: cell 0 registers the word at the accepting edge and each later cell
//   registers it in turn; rsp shows the last cell's registers.
// Flow: one item at a time; req.ready stays low from acceptance until the
//   response is taken.
// Reset: the fill level and all handshake state clear; stored entries are left
//   as they are and are never read before being written.
// Stall: while rsp.ready is low the last cell holds the response word steady.
module address_keyed_call_counter_core import akcc_pkg::*; #(
	parameter int ENTRIES    = AKCC_ENTRIES,
	parameter int ADDR_BITS  = AKCC_ADDR_BITS,
	parameter int COUNT_BITS = AKCC_COUNT_BITS
) (
	input logic           clk,
	input logic           arst_n,
	akcc_req_if.sink      req,
	akcc_rsp_if.source    rsp
);

	localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int FILL_BITS = $clog2(ENTRIES + 1);

	// Word chain between cells: slot k feeds cell k, slot k+1 takes its output.
	logic                  vld_w  [ENTRIES+1];
	tok_ctl_t              ctl_w  [ENTRIES+1];
	logic [ADDR_BITS-1:0]  key_w  [ENTRIES+1];
	logic [IDX_BITS-1:0]   idx_w  [ENTRIES+1];
	logic [IDX_BITS-1:0]   ridx_w [ENTRIES+1];
	logic [COUNT_BITS-1:0] rcnt_w [ENTRIES+1];

	logic [FILL_BITS-1:0]  fill_q;
	logic                  busy_q;
	logic                  req_take;
	logic                  rsp_take;
	tok_ctl_t              last_ctl;

	// One item in flight: hold off new requests until the response leaves.
	assign req.ready = !busy_q;
	assign req_take  = req.valid && req.ready;
	assign rsp_take  = rsp.valid && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req_take) begin
			busy_q <= 1'b1;
		end else if (rsp_take) begin
			busy_q <= 1'b0;
		end
	end

	// Advance the fill level once the inserting word has left; the cells see
	// the old level during the whole walk, which the insert rule relies on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (rsp_take && last_ctl.fresh) begin
			fill_q <= fill_q + FILL_BITS'(1);
		end
	end

	// Chain entry: the accepted request word with a clean result.
	assign vld_w[0]  = req_take;
	assign ctl_w[0]  = '{op: req.func, done: 1'b0, fresh: 1'b0};
	assign key_w[0]  = req.address;
	assign idx_w[0]  = req.index;
	assign ridx_w[0] = '0;
	assign rcnt_w[0] = '0;

	for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
		akcc_cell #(
			.POS        (k),
			.ADDR_BITS  (ADDR_BITS),
			.COUNT_BITS (COUNT_BITS),
			.IDX_BITS   (IDX_BITS),
			.FILL_BITS  (FILL_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.fill     (fill_q),
			// Only the last cell waits on the receiver.
			.hold     ((k == ENTRIES - 1) ? !rsp.ready : 1'b0),
			.in_vld   (vld_w[k]),
			.in_ctl   (ctl_w[k]),
			.in_key   (key_w[k]),
			.in_idx   (idx_w[k]),
			.in_ridx  (ridx_w[k]),
			.in_rcnt  (rcnt_w[k]),
			.out_vld  (vld_w[k+1]),
			.out_ctl  (ctl_w[k+1]),
			.out_key  (key_w[k+1]),
			.out_idx  (idx_w[k+1]),
			.out_ridx (ridx_w[k+1]),
			.out_rcnt (rcnt_w[k+1])
		);
	end

	// Response word from the last cell's registers. A word that found no
	// entry reports zeros; a record word that found none was dropped.
	assign last_ctl          = ctl_w[ENTRIES];
	assign rsp.valid         = vld_w[ENTRIES];
	assign rsp.entry_valid   = last_ctl.done;
	assign rsp.was_new       = last_ctl.fresh;
	assign rsp.dropped_full  = (last_ctl.op == OP_RECORD) && !last_ctl.done;
	assign rsp.entry_index   = last_ctl.done ? ridx_w[ENTRIES] : '0;
	assign rsp.entry_address = last_ctl.done ? key_w[ENTRIES] : '0;
	assign rsp.hit_count     = last_ctl.done ? rcnt_w[ENTRIES] : '0;

	// The read index is consumed inside the chain; the final copy is unused.
	logic [IDX_BITS-1:0] idx_tail_unused;
	assign idx_tail_unused = idx_w[ENTRIES];

endmodule

FILE: rtl/core/akcc_checker.sv
// Port-level checker of the call counter, bound to the top level.
`include "address_keyed_call_counter_core_assert.svh"

module akcc_checker import akcc_pkg::*; #(
	parameter int ADDR_BITS  = AKCC_ADDR_BITS,
	parameter int COUNT_BITS = AKCC_COUNT_BITS,
	parameter int IDX_BITS   = 6
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_ready,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input logic [IDX_BITS-1:0]   entry_index,
	input logic [ADDR_BITS-1:0]  entry_address,
	input logic [COUNT_BITS-1:0] hit_count,
	input logic                  was_new,
	input logic                  entry_valid,
	input logic                  dropped_full
);

	logic drop_clean;
	logic entry_sound;

	assign drop_clean  = !entry_valid && !was_new && entry_index == '0
		&& entry_address == '0 && hit_count == '0;
	assign entry_sound = hit_count != '0 && !dropped_full;

	// A taken request blocks the next one.
	`AKCC_ASSERT_NEXT(a_busy_after_take, clk, arst_n, req_valid && req_ready, !req_ready)

	// Never open for a request while a response waits.
	`AKCC_ASSERT_IMPL(a_single_flight, clk, arst_n, rsp_valid, !req_ready)

	// A stalled response stays up.
	`AKCC_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)

	// A drop reports no entry and zero fields; a real entry has a nonzero count.
	`AKCC_ASSERT_IMPL(a_drop_fields, clk, arst_n, rsp_valid && dropped_full, drop_clean)
	`AKCC_ASSERT_IMPL(a_valid_count, clk, arst_n, rsp_valid && entry_valid, entry_sound)

endmodule

bind address_keyed_call_counter_core akcc_checker #(
	.ADDR_BITS  (ADDR_BITS),
	.COUNT_BITS (COUNT_BITS),
	.IDX_BITS   (IDX_BITS)
) u_akcc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.entry_index   (rsp.entry_index),
	.entry_address (rsp.entry_address),
	.hit_count     (rsp.hit_count),
	.was_new       (rsp.was_new),
	.entry_valid   (rsp.entry_valid),
	.dropped_full  (rsp.dropped_full)
);
